>>> sv/mfde_pkg.sv
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and constants of the monochrome frame buffer draw engine.
// ----------------------------------------------------------------------------
`default_nettype none
package mfde_pkg;
	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 64;
	localparam int FB_PAGES     = (PANEL_HEIGHT + 7) / 8;
	localparam int FB_BYTES     = PANEL_WIDTH * FB_PAGES;
	localparam int ADDR_W       = $clog2(FB_BYTES);
	// signed coordinate width, wide enough for centre +/- radius
	localparam int CRD_W        = 10;

	typedef enum logic [2:0] {
		MODE_SET   = 3'd0,
		MODE_CLEAR = 3'd1,
		MODE_LINE  = 3'd2,
		MODE_CIRC  = 3'd3,
		MODE_CLS   = 3'd4,
		MODE_READ  = 3'd5,
		MODE_RSV6  = 3'd6,
		MODE_RSV7  = 3'd7
	} mode_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [6:0]  x_first;
		logic [5:0]  y_first;
		logic [6:0]  x_second;
		logic [5:0]  y_second;
		logic [6:0]  radius;
		logic [9:0]  byte_address;
	} req_t;

	typedef struct packed {
		logic       status;
		logic [7:0] read_data;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIV,
		ST_LPLOT,
		ST_LRD,
		ST_LWR,
		ST_LEND,
		ST_CPT,
		ST_CRD,
		ST_CWR,
		ST_CUPD,
		ST_PRD,
		ST_PWR,
		ST_CLS,
		ST_RRD,
		ST_RWT,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

>>> sv/mfde_fb.sv
// ----------------------------------------------------------------------------
// mfde_fb
// Frame buffer memory with registered read and single write port.
// ----------------------------------------------------------------------------
`default_nettype none
module mfde_fb import mfde_pkg::*; (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [7:0]        wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [7:0]        rdata
);
	logic [7:0] mem [FB_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> sv/mfde_div.sv
// ----------------------------------------------------------------------------
// mfde_div
// Restoring divider, one quotient bit a cycle, for the line slope.
// ----------------------------------------------------------------------------
`default_nettype none
module mfde_div import mfde_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [23:0] dividend,
	input  wire logic [7:0]  divisor,
	output logic             busy,
	output logic [23:0]      quotient
);
	logic [23:0] quo_q;
	logic [8:0]  rem_q;
	logic [7:0]  dvs_q;
	logic [4:0]  cnt_q;
	logic [8:0]  trial;
	logic [8:0]  diff;

	assign trial    = {rem_q[7:0], quo_q[23]};
	assign diff     = trial - {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 5'd23;
		end else if (busy) begin
			if (cnt_q == 5'd0) begin
				busy <= 1'b0;
			end
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!diff[8]) begin
				rem_q <= diff;
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/mono_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Draw engine for a 128x64 page-organised monochrome frame buffer.
// ----------------------------------------------------------------------------
// One request at a time; ready is low while a request is being worked.
// Each pixel costs a read-modify-write of its buffer byte through the
// buffer's read and write ports (address, read, write); a set or clear is
// one such read-modify-write. A line first divides for its slope, then
// plots each pixel in turn; a circle plots eight candidate points per step
// plus one update; clear screen writes one byte a cycle. After reset the
// buffer is swept to zero, during which no request is accepted. The result
// sits in an output register, so the next request is taken while it waits;
// that request holds at its end until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module mono_framebuffer_draw_engine import mfde_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire req_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output rsp_t      out_data
);
	state_t state_q, state_d;
	req_t   req_q;
	logic   init_q;

	// buffer port
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]        wdata, rdata;

	// clear sweep
	logic [ADDR_W:0] sweep_q;

	// pixel register (target of current read-modify-write)
	logic signed [CRD_W-1:0] px_q, py_q;
	logic                    pset_q;
	logic                    pon;
	logic [ADDR_W-1:0]       paddr;
	logic [7:0]              pbit;

	// line state
	logic        xmaj_q, mneg_q, pneg_q;
	logic [6:0]  pos_q, endp_q;
	logic [23:0] acc_q, k_q;
	logic        div_start, div_busy;
	logic        div_go_q;
	logic [23:0] div_q;
	logic [6:0]  dx, dy, major, minor;
	logic [7:0]  macc;

	// circle state
	logic signed [CRD_W-1:0] cx_q, cy_q;
	logic signed [CRD_W+2:0] d_q;
	logic [2:0]              oct_q;
	logic signed [CRD_W-1:0] ox, oy;

	logic       stat_q;
	logic [7:0] rdat_q;

	mfde_fb u_fb (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	mfde_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({1'b0, minor, 16'd0}),
		.divisor ({1'b0, major}),
		.busy    (div_busy),
		.quotient(div_q)
	);

	assign dx    = (req_q.x_second > req_q.x_first) ?
		req_q.x_second - req_q.x_first : req_q.x_first - req_q.x_second;
	assign dy    = (7'(req_q.y_second) > 7'(req_q.y_first)) ?
		7'(req_q.y_second) - 7'(req_q.y_first) : 7'(req_q.y_first) - 7'(req_q.y_second);
	assign major = (dx > dy) ? dx : dy;
	assign minor = (dx > dy) ? dy : dx;
	assign macc  = 8'((acc_q + 24'h8000) >> 16);

	// pixel address of the current target
	assign pon   = (px_q >= 0) && (px_q < CRD_W'(PANEL_WIDTH))
		&& (py_q >= 0) && (py_q < CRD_W'(PANEL_HEIGHT));
	assign paddr = ADDR_W'((py_q >>> 3) * PANEL_WIDTH + px_q);
	assign pbit  = 8'd1 << py_q[2:0];

	// octant point selection
	always_comb begin
		unique case (oct_q)
			3'd0: begin ox = cx_q;  oy = cy_q;  end
			3'd1: begin ox = -cx_q; oy = cy_q;  end
			3'd2: begin ox = cx_q;  oy = -cy_q; end
			3'd3: begin ox = -cx_q; oy = -cy_q; end
			3'd4: begin ox = cy_q;  oy = cx_q;  end
			3'd5: begin ox = -cy_q; oy = cx_q;  end
			3'd6: begin ox = cy_q;  oy = -cx_q; end
			default: begin ox = -cy_q; oy = -cx_q; end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (init_q) begin
					state_d = ST_CLS;
				end else if (in_valid && in_ready) begin
					unique case (mode_t'(in_data.mode))
						MODE_SET, MODE_CLEAR: state_d = ST_PRD;
						MODE_LINE:            state_d = ST_DIV;
						MODE_CIRC:            state_d = ST_CUPD;
						MODE_CLS:             state_d = ST_CLS;
						MODE_READ:            state_d = ST_RRD;
						default:              state_d = ST_DONE;
					endcase
				end
			end
			ST_PRD:  state_d = ST_PWR;
			ST_PWR:  state_d = ST_DONE;
			ST_DIV: begin
				if (!div_busy && !div_start) begin
					state_d = ST_LPLOT;
				end
			end
			ST_LPLOT: state_d = ST_LRD;
			ST_LRD:   state_d = ST_LWR;
			ST_LWR:   state_d = (pos_q == endp_q) ? ST_DONE : ST_LPLOT;
			ST_LEND:  state_d = ST_DONE;
			ST_CUPD:  state_d = (cx_q < cy_q) ? ST_CPT : ST_DONE;
			ST_CPT:   state_d = ST_CRD;
			ST_CRD:   state_d = ST_CWR;
			ST_CWR:   state_d = (oct_q == 3'd7) ? ST_CUPD : ST_CPT;
			ST_CLS: begin
				if (sweep_q == (ADDR_W+1)'(FB_BYTES - 1)) begin
					state_d = init_q ? ST_IDLE : ST_DONE;
				end
			end
			ST_RRD:  state_d = ST_RWT;
			ST_RWT:  state_d = ST_DONE;
			ST_DONE: state_d = out_valid ? ST_DONE : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = (state_q == ST_IDLE) && !init_q;
		// divider starts once the operands sit in req_q
		div_start = div_go_q;
		we        = 1'b0;
		waddr     = paddr;
		wdata     = pset_q ? (rdata | pbit) : (rdata & ~pbit);
		raddr     = paddr;
		unique case (state_q)
			ST_CLS: begin
				we    = 1'b1;
				waddr = sweep_q[ADDR_W-1:0];
				wdata = '0;
			end
			ST_RRD: raddr = req_q.byte_address[ADDR_W-1:0];
			ST_PWR, ST_LWR, ST_CWR: we = pon;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			init_q    <= 1'b1;
			sweep_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLS) begin
				if (state_d != ST_CLS) begin
					init_q  <= 1'b0;
					sweep_q <= '0;
				end else begin
					sweep_q <= sweep_q + 1'b1;
				end
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end else if (state_q == ST_DONE && !out_valid) begin
				out_valid <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q    <= in_data;
				stat_q   <= 1'b0;
				out_data <= out_data;
				pset_q   <= (mode_t'(in_data.mode) != MODE_CLEAR);
				px_q     <= CRD_W'(in_data.x_first);
				py_q     <= CRD_W'(in_data.y_first);
				cx_q     <= '0;
				cy_q     <= CRD_W'(in_data.radius);
				d_q      <= (CRD_W+3)'(3) - ((CRD_W+3)'(in_data.radius) <<< 1);
				oct_q    <= '0;
				if (in_valid && in_ready) begin
					unique case (mode_t'(in_data.mode))
						MODE_SET, MODE_CLEAR: stat_q <= !(CRD_W'(in_data.x_first)
							< CRD_W'(PANEL_WIDTH) && CRD_W'(in_data.y_first)
							< CRD_W'(PANEL_HEIGHT));
						MODE_LINE, MODE_CIRC, MODE_CLS: stat_q <= 1'b0;
						MODE_READ: stat_q <= !(11'(in_data.byte_address)
							< 11'(FB_BYTES));
						default: stat_q <= 1'b1;
					endcase
				end
			end
			ST_DIV: begin
				xmaj_q <= dx > dy;
				mneg_q <= (dx > dy) ? (req_q.y_second < req_q.y_first)
					: (req_q.x_second < req_q.x_first);
				pneg_q <= (dx > dy) ? (req_q.x_second < req_q.x_first)
					: (req_q.y_second < req_q.y_first);
				pos_q  <= (dx > dy) ? req_q.x_first : 7'(req_q.y_first);
				endp_q <= (dx > dy) ? req_q.x_second : 7'(req_q.y_second);
				acc_q  <= (dx > dy) ? {2'b0, req_q.y_first, 16'd0}
					: {1'b0, req_q.x_first, 16'd0};
				k_q    <= div_q;
			end
			ST_LPLOT: begin
				if (pos_q == endp_q) begin
					px_q <= CRD_W'(req_q.x_second);
					py_q <= CRD_W'(req_q.y_second);
				end else if (xmaj_q) begin
					px_q <= CRD_W'(pos_q);
					py_q <= CRD_W'(macc);
				end else begin
					px_q <= CRD_W'(macc);
					py_q <= CRD_W'(pos_q);
				end
			end
			ST_LWR: begin
				pos_q <= pneg_q ? pos_q - 7'd1 : pos_q + 7'd1;
				acc_q <= mneg_q ? acc_q - k_q : acc_q + k_q;
			end
			ST_CPT: begin
				px_q <= CRD_W'(req_q.x_first) + ox;
				py_q <= CRD_W'(req_q.y_first) + oy;
			end
			ST_CWR: begin
				oct_q <= oct_q + 3'd1;
				if (oct_q == 3'd7) begin
					if (d_q < 0) begin
						d_q <= d_q + (CRD_W+3)'(cx_q <<< 2) + (CRD_W+3)'(6);
					end else begin
						// y steps down: d += 4 * (x - y + 1) + 10
						cy_q <= cy_q - 1'b1;
						d_q  <= d_q + ((CRD_W+3)'(cx_q - cy_q) <<< 2)
							+ (CRD_W+3)'(14);
					end
					cx_q <= cx_q + 1'b1;
				end
			end
			ST_RWT: rdat_q <= stat_q ? 8'd0 : rdata;
			ST_DONE: begin
				if (!out_valid) begin
					out_data.status    <= stat_q;
					out_data.read_data <= (mode_t'(req_q.mode) == MODE_READ) ?
						rdat_q : 8'd0;
				end
			end
			default: ;
		endcase
	end

	// slope divider launch: registered, high in the first cycle of the divide state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= (state_q == ST_IDLE) && (state_d == ST_DIV);
		end
	end
endmodule
`default_nettype wire

>>> test/tb_mono_framebuffer_draw_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_draw_engine
// Self-checking bench for the monochrome frame buffer draw engine.
// ----------------------------------------------------------------------------
// A local copy of the frame buffer is drawn into as each request is accepted.
// That gives the status and read-back byte to expect for every request. A
// monitor compares each response with the oldest expectation. Read-back
// requests are mixed into every phase so that drawing errors show up.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_mono_framebuffer_draw_engine;
	import mfde_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	mono_framebuffer_draw_engine uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local copy of the panel memory
	logic [7:0] shadow_fb [FB_BYTES];
	req_t       pending_reqs [$];
	rsp_t       expected_rsps [$];
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         error_count = 0;
	int         rsp_count = 0;
	int         mode_hits [8];
	bit         stim_done = 1'b0;

	// plot into the shadow copy; off-panel points give 1
	function automatic bit shadow_pixel(int x, int y, bit set);
		int a;
		if (x < 0 || x >= PANEL_WIDTH || y < 0 || y >= PANEL_HEIGHT)
			return 1'b1;
		a = (y / 8) * PANEL_WIDTH + x;
		if (set)
			shadow_fb[a] |= 8'(1 << (y % 8));
		else
			shadow_fb[a] &= ~8'(1 << (y % 8));
		return 1'b0;
	endfunction

	// dda along the major axis, minor rounded from a 16.16 accumulator
	function automatic bit shadow_line(int x1, int y1, int x2, int y2);
		int dx, dy, sx, sy, major, minor, pos, endp;
		bit xmajor, dummy;
		logic [31:0] slope, acc;
		int m;
		if (x1 >= PANEL_WIDTH || x2 >= PANEL_WIDTH || y1 >= PANEL_HEIGHT ||
		    y2 >= PANEL_HEIGHT)
			return 1'b1;
		if (x1 == x2 && y1 == y2) begin
			dummy = shadow_pixel(x1, y1, 1'b1);
			return 1'b0;
		end
		dx = x2 > x1 ? x2 - x1 : x1 - x2;
		dy = y2 > y1 ? y2 - y1 : y1 - y2;
		sx = x1 < x2 ? 1 : -1;
		sy = y1 < y2 ? 1 : -1;
		xmajor = dx > dy;
		major = xmajor ? dx : dy;
		minor = xmajor ? dy : dx;
		slope = (32'(minor) << 16) / 32'(major);
		acc = 32'(xmajor ? y1 : x1) << 16;
		pos = xmajor ? x1 : y1;
		endp = xmajor ? x2 : y2;
		while (pos != endp) begin
			m = int'((acc + 32'h8000) >> 16);
			if (xmajor) begin
				dummy = shadow_pixel(pos, m, 1'b1);
				pos += sx;
				acc = sy > 0 ? acc + slope : acc - slope;
			end else begin
				dummy = shadow_pixel(m, pos, 1'b1);
				pos += sy;
				acc = sx > 0 ? acc + slope : acc - slope;
			end
		end
		dummy = shadow_pixel(x2, y2, 1'b1);
		return 1'b0;
	endfunction

	// midpoint circle, eight octants, clipped points skipped
	function automatic void shadow_circle(int xc, int yc, int r);
		int x, y, d;
		bit dummy;
		y = r;
		d = 3 - 2 * r;
		for (x = 0; x < y; x++) begin
			dummy = shadow_pixel(xc + x, yc + y, 1'b1);
			dummy = shadow_pixel(xc - x, yc + y, 1'b1);
			dummy = shadow_pixel(xc + x, yc - y, 1'b1);
			dummy = shadow_pixel(xc - x, yc - y, 1'b1);
			dummy = shadow_pixel(xc + y, yc + x, 1'b1);
			dummy = shadow_pixel(xc - y, yc + x, 1'b1);
			dummy = shadow_pixel(xc + y, yc - x, 1'b1);
			dummy = shadow_pixel(xc - y, yc - x, 1'b1);
			if (d < 0)
				d = d + 4 * x + 6;
			else begin
				y--;
				d = d + 4 * (x - y) + 10;
			end
		end
	endfunction

	// apply one accepted request to the shadow copy and queue its response
	function automatic void predict_draw(req_t r);
		rsp_t e;
		e = '0;
		mode_hits[r.mode]++;
		case (mode_t'(r.mode))
			MODE_SET:   e.status = shadow_pixel(r.x_first, r.y_first, 1'b1);
			MODE_CLEAR: e.status = shadow_pixel(r.x_first, r.y_first, 1'b0);
			MODE_LINE:  e.status = shadow_line(r.x_first, r.y_first, r.x_second,
				r.y_second);
			MODE_CIRC:  shadow_circle(r.x_first, r.y_first, r.radius);
			MODE_CLS: begin
				foreach (shadow_fb[i])
					shadow_fb[i] = '0;
			end
			MODE_READ: begin
				if (r.byte_address < FB_BYTES)
					e.read_data = shadow_fb[r.byte_address];
				else
					e.status = 1'b1;
			end
			default: e.status = 1'b1;
		endcase
		expected_rsps.push_back(e);
	endfunction

	function automatic req_t make_req(mode_t m, int xa, int ya, int xb, int yb,
		int r, int a);
		req_t q;
		q.mode = m;
		q.x_first = 7'(xa);
		q.y_first = 6'(ya);
		q.x_second = 7'(xb);
		q.y_second = 6'(yb);
		q.radius = 7'(r);
		q.byte_address = 10'(a);
		return q;
	endfunction

	// random request: mostly drawing plus read-back, small radii usually
	function automatic req_t rand_req();
		req_t q;
		int pick;
		q = req_t'(46'({$urandom, $urandom}));
		pick = $urandom_range(0, 99);
		if (pick < 18)
			q.mode = MODE_SET;
		else if (pick < 28)
			q.mode = MODE_CLEAR;
		else if (pick < 43)
			q.mode = MODE_LINE;
		else if (pick < 53)
			q.mode = MODE_CIRC;
		else if (pick < 55)
			q.mode = MODE_CLS;
		else if (pick < 97)
			q.mode = MODE_READ;
		else
			q.mode = $urandom_range(0, 1) ? MODE_RSV6 : MODE_RSV7;
		// favor the left half of the panel most of the time
		if ($urandom_range(0, 9) != 0) begin
			q.x_first[6] = q.x_first[6] & 1'($urandom_range(0, 1));
			q.x_second[6] = q.x_second[6] & 1'($urandom_range(0, 1));
		end
		if (q.mode == MODE_CIRC && $urandom_range(0, 19) != 0)
			q.radius = 7'($urandom_range(0, 40));
		// read-back address mostly inside the buffer
		if ($urandom_range(0, 9) != 0)
			q.byte_address = 10'($urandom_range(0, FB_BYTES - 1));
		return q;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!in_valid || in_ready) begin
			if (in_valid && in_ready)
				predict_draw(in_data);
			if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_data <= pending_reqs.pop_front();
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t e;
		if (out_valid && out_ready) begin
			rsp_count++;
			if (expected_rsps.size() == 0) begin
				$error("response with no request pending");
				error_count++;
			end else begin
				e = expected_rsps.pop_front();
				if (out_data.status !== e.status) begin
					$error("status: expected %0d got %0d", e.status, out_data.status);
					error_count++;
				end
				if (out_data.read_data !== e.read_data) begin
					$error("read_data: expected %02h got %02h", e.read_data,
						out_data.read_data);
					error_count++;
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int phase;
		foreach (shadow_fb[i])
			shadow_fb[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners, edges, every mode, special cases
		pending_reqs.push_back(make_req(MODE_READ, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_SET, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_SET, 127, 63, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_READ, 0, 0, 0, 0, 0, 1023));
		pending_reqs.push_back(make_req(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_READ, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_SET, 127, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_CLEAR, 127, 63, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_LINE, 0, 0, 127, 63, 0, 0));
		pending_reqs.push_back(make_req(MODE_LINE, 127, 0, 0, 63, 0, 0));
		pending_reqs.push_back(make_req(MODE_LINE, 5, 60, 9, 2, 0, 0));
		pending_reqs.push_back(make_req(MODE_LINE, 20, 20, 20, 20, 0, 0));
		pending_reqs.push_back(make_req(MODE_LINE, 0, 10, 100, 10, 0, 0));
		pending_reqs.push_back(make_req(MODE_LINE, 0, 0, 0, 63, 0, 0));
		// bottom edge set and a shallow line across the panel
		pending_reqs.push_back(make_req(MODE_SET, 3, 63, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_LINE, 0, 0, 127, 10, 0, 0));
		pending_reqs.push_back(make_req(MODE_CIRC, 64, 32, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_CIRC, 64, 32, 0, 0, 1, 0));
		pending_reqs.push_back(make_req(MODE_CIRC, 0, 0, 0, 0, 127, 0));
		pending_reqs.push_back(make_req(MODE_CIRC, 127, 63, 0, 0, 20, 0));
		pending_reqs.push_back(make_req(MODE_READ, 0, 0, 0, 0, 0, 900));
		pending_reqs.push_back(make_req(MODE_RSV6, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_RSV7, 127, 63, 127, 63, 127, 1023));
		pending_reqs.push_back(make_req(MODE_CLS, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_READ, 0, 0, 0, 0, 0, 500));
		drain();

		// random phases with varying back-pressure and gaps
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			repeat (375)
				pending_reqs.push_back(rand_req());
			drain();
		end
		repeat (50) @(posedge clk);
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		$display("covered %0d responses: set %0d clear %0d line %0d circle %0d",
			rsp_count, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		$display("clear-screen %0d, read-back %0d, unused modes %0d",
			mode_hits[4], mode_hits[5], mode_hits[6] + mode_hits[7]);
		if (error_count == 0 && expected_rsps.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#40ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
